### design/swpd_pkg.sv
`timescale 1ns / 1ps

package swpd_pkg;

    localparam int SCREEN_BYTES_DEF = 32768;

    localparam int PIX_W    = 17;
    localparam int OFF_W    = 15;
    localparam int DATA_W   = 32;
    localparam int SHADOW_W = 16;
    localparam int IDX_W    = 3;
    localparam int RGB_W    = 24;
    localparam int APB_AW   = 3;

    // write size codes
    localparam logic [1:0] ACT_BYTE = 2'd0;
    localparam logic [1:0] ACT_WORD = 2'd1;
    localparam logic [1:0] ACT_LONG = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    // register index
    localparam logic REG_MODE = 1'b0;

    // one screen word handed to the pixel emitter
    typedef struct packed {
        logic [PIX_W-1:0]    pix_base;
        logic [SHADOW_W-1:0] word;
        logic                last;
    } job_t;

    // colour number for column col of a screen word
    function automatic logic [IDX_W-1:0] pixel_colour(
        input logic [SHADOW_W-1:0] word,
        input logic [2:0]          col,
        input logic                eight_mode
    );
        logic [7:0] hi;
        logic [7:0] lo;
        logic [2:0] b;
        logic [2:0] b1;
        logic       g;
        logic       r;
        hi = word[15:8];
        lo = word[7:0];
        if (eight_mode) begin
            b  = {col[2:1], 1'b0} ^ 3'b110;
            b1 = b | 3'b001;
            pixel_colour = {hi[b1], lo[b1], lo[b]};
        end else begin
            b = ~col;
            g = hi[b];
            r = lo[b];
            pixel_colour = {g, r, g & r};
        end
    endfunction

    function automatic logic [RGB_W-1:0] palette_rgb(input logic [IDX_W-1:0] idx);
        logic [RGB_W-1:0] rgb;
        case (idx)
            3'd0:    rgb = 24'h000000;
            3'd1:    rgb = 24'h0000FF;
            3'd2:    rgb = 24'hFF0000;
            3'd3:    rgb = 24'hFF00FF;
            3'd4:    rgb = 24'h00FF00;
            3'd5:    rgb = 24'h00FFFF;
            3'd6:    rgb = 24'hFFFF00;
            default: rgb = 24'hFFFFFF;
        endcase
        return rgb;
    endfunction

endpackage

### design/swpd_pixel_out.sv
`timescale 1ns / 1ps

module swpd_pixel_out (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        eight_mode,
    input  logic                        job_valid,
    input  swpd_pkg::job_t              job,
    output logic                        job_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [swpd_pkg::PIX_W-1:0]  m_pixel_index,
    output logic [swpd_pkg::IDX_W-1:0]  m_palette_index,
    output logic [swpd_pkg::RGB_W-1:0]  m_pixel_rgb,
    output logic                        m_last
);
    import swpd_pkg::*;

    job_t              cur_reg;
    logic              cur_valid_reg;
    logic              cur_valid_next;
    logic [2:0]        col_reg;
    logic [2:0]        col_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [PIX_W-1:0]  pix_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [RGB_W-1:0]  rgb_reg;
    logic              last_reg;

    logic              emit;
    logic              job_done;
    logic [IDX_W-1:0]  colour;

    assign emit      = cur_valid_reg && (!m_valid_reg || m_ready);
    assign job_done  = emit && (col_reg == 3'd7);
    assign job_ready = !cur_valid_reg || job_done;
    assign colour    = pixel_colour(cur_reg.word, col_reg, eight_mode);

    always_comb begin
        cur_valid_next = cur_valid_reg;
        col_next       = col_reg;
        if (emit) begin
            col_next = col_reg + 3'd1;
        end
        if (job_done) begin
            cur_valid_next = 1'b0;
        end
        if (job_valid && job_ready) begin
            cur_valid_next = 1'b1;
            col_next       = 3'd0;
        end
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            col_reg       <= 3'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            col_reg       <= col_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_valid && job_ready) begin
            cur_reg <= job;
        end
        if (emit) begin
            // base has its low three bits clear, so the add is a plain OR
            pix_reg  <= cur_reg.pix_base | PIX_W'(col_reg);
            idx_reg  <= colour;
            rgb_reg  <= palette_rgb(colour);
            last_reg <= cur_reg.last && (col_reg == 3'd7);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_index   = pix_reg;
    assign m_palette_index = idx_reg;
    assign m_pixel_rgb     = rgb_reg;
    assign m_last          = last_reg;

endmodule

### design/screen_write_pixel_decode_unit.sv
`timescale 1ns / 1ps
// Flow: a write is accepted into the merge stage registers as its shadow word is read, merged and
//   written back as it enters the emitter's job register, and its pixels are registered onto m_.
// Throughput: 8 pixels per byte or word write and 16 per long write, sent by the pixel emitter
//   one pixel per cycle while m_ready is high; the next write is taken while pixels drain.
// Reset: synchronous, active low. The shadow memory is then zeroed one entry per cycle,
//   all SCREEN_BYTES/2 entries (16384 by default), with s_ready low; register writes still work.

module screen_write_pixel_decode_unit #(
    // power of two, 2048 to 32768
    parameter int SCREEN_BYTES = swpd_pkg::SCREEN_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swpd_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // write input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_action,
    input  logic [swpd_pkg::OFF_W-1:0]    s_byte_offset,
    input  logic [swpd_pkg::DATA_W-1:0]   s_write_data,
    // pixel output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [swpd_pkg::PIX_W-1:0]    m_pixel_index,
    output logic [swpd_pkg::IDX_W-1:0]    m_palette_index,
    output logic [swpd_pkg::RGB_W-1:0]    m_pixel_rgb,
    output logic                          m_last
);
    import swpd_pkg::*;

    localparam int WORDS = SCREEN_BYTES / 2;
    localparam int OW    = $clog2(SCREEN_BYTES);          // byte offset width
    localparam int AW    = OW - 1;                        // shadow word address width
    localparam int EW    = (OW > OFF_W) ? OW : OFF_W;
    localparam int PW    = (OW + 2 > PIX_W) ? OW + 2 : PIX_W;

    // ---------------------------------------------------------------
    // Mode register
    // ---------------------------------------------------------------
    logic mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODE)) begin
            mode_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE) ? {31'd0, mode_reg} : 32'd0;

    // ---------------------------------------------------------------
    // Shadow memory and clearing pass
    // ---------------------------------------------------------------
    logic [SHADOW_W-1:0] shadow_mem [WORDS];
    logic [SHADOW_W-1:0] rd_data_reg;
    logic                clearing_reg;
    logic [AW-1:0]       clr_addr_reg;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [SHADOW_W-1:0] mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic                accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(WORDS - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            shadow_mem[mem_waddr] <= mem_wdata;
        end
        // read only on accept: the word must survive a stalled merge stage
        if (accept) begin
            rd_data_reg <= shadow_mem[mem_raddr];
        end
    end

    // ---------------------------------------------------------------
    // Input side: wrap the offset and read the shadow word
    // ---------------------------------------------------------------
    logic [EW-1:0] off_ext;
    logic [OW-1:0] in_off;

    assign off_ext   = EW'(s_byte_offset);
    assign in_off    = {off_ext[OW-1:1], 1'b0};
    assign mem_raddr = in_off[OW-1:1];

    // ---------------------------------------------------------------
    // Merge stage: one item, one or two word writes
    // ---------------------------------------------------------------
    logic                p1_valid_reg;
    logic [1:0]          p1_action_reg;
    logic [OW-1:0]       p1_off_reg;
    logic                p1_odd_reg;
    logic [DATA_W-1:0]   p1_data_reg;
    logic                p1_phase_reg;
    logic                fwd_hit_reg;
    logic [SHADOW_W-1:0] fwd_data_reg;

    logic                long_first;
    logic                push;
    logic                p1_done;
    logic [OW-1:0]       wr_off;
    logic [SHADOW_W-1:0] old_word;
    logic [SHADOW_W-1:0] wr_word;
    logic [PW-1:0]       base_w;
    logic                job_ready;
    job_t                job;

    assign long_first = (p1_action_reg == ACT_LONG) && !p1_phase_reg;
    assign push       = p1_valid_reg && job_ready;
    assign p1_done    = push && !long_first;
    assign s_ready    = !clearing_reg && (!p1_valid_reg || p1_done);
    assign accept     = s_valid && s_ready;

    // second word of a long write wraps with the screen
    assign wr_off   = p1_phase_reg ? (p1_off_reg + OW'(2)) : p1_off_reg;
    // a write landing on the word being read in the same cycle is forwarded
    assign old_word = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    always_comb begin
        case (p1_action_reg)
            ACT_BYTE: begin
                wr_word = p1_odd_reg ? {old_word[15:8], p1_data_reg[7:0]}
                                     : {p1_data_reg[7:0], old_word[7:0]};
            end
            ACT_LONG: begin
                wr_word = p1_phase_reg ? p1_data_reg[15:0] : p1_data_reg[31:16];
            end
            default: begin
                wr_word = p1_data_reg[15:0];
            end
        endcase
    end

    assign base_w       = PW'({wr_off, 2'b00});
    assign job.pix_base = base_w[PIX_W-1:0];
    assign job.word     = wr_word;
    assign job.last     = !long_first;

    assign mem_we    = clearing_reg || push;
    assign mem_waddr = clearing_reg ? clr_addr_reg : wr_off[OW-1:1];
    assign mem_wdata = clearing_reg ? '0 : wr_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p1_phase_reg <= 1'b0;
        end else begin
            if (accept) begin
                // unused action code is swallowed here
                p1_valid_reg <= (s_action != ACT_NONE);
                p1_phase_reg <= 1'b0;
            end else if (p1_done) begin
                p1_valid_reg <= 1'b0;
            end else if (push) begin
                p1_phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_action_reg <= s_action;
            p1_off_reg    <= in_off;
            p1_odd_reg    <= s_byte_offset[0];
            p1_data_reg   <= s_write_data;
            fwd_hit_reg   <= push && (wr_off[OW-1:1] == mem_raddr);
            fwd_data_reg  <= wr_word;
        end
    end

    // ---------------------------------------------------------------
    // Pixel emitter
    // ---------------------------------------------------------------
    swpd_pixel_out u_pixel_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .eight_mode      (mode_reg),
        .job_valid       (p1_valid_reg),
        .job             (job),
        .job_ready       (job_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_index   (m_pixel_index),
        .m_palette_index (m_palette_index),
        .m_pixel_rgb     (m_pixel_rgb),
        .m_last          (m_last)
    );

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_accept_while_clearing: assert property (
        @(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_ready
    ) else $error("write taken during shadow clear");

    a_long_second_word: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (push && long_first) |=> (p1_valid_reg && p1_phase_reg)
    ) else $error("long write lost its second word");

    a_last_on_final_column: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_pixel_index[2:0] == 3'd7)
    ) else $error("last flag not on column seven");

    a_merge_waits_for_clear: assert property (
        @(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !p1_valid_reg
    ) else $error("merge stage busy during shadow clear");

endmodule
